[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the depth sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define DSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that must never be true outside reset.
`define DSF_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

[hw/rtl/dsf_pkg.sv]
// Types and constants of the far-to-near depth sorter.
package dsf_pkg;

    localparam int KEY_W = 32;
    localparam int IDX_W = 6;
    localparam int Q_DEPTH = 2;
    localparam int Q_PW = 1;
    localparam logic [1:0] Q_FULL_CNT = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] depth_key;
        logic                    last_item;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        item_index;
        logic signed [KEY_W-1:0] sorted_key;
        logic                    last_out;
        logic                    overflowed;
    } t_out_item;

    // Queue entry from the front end to the sorter.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        idx;
        logic                    last;
        logic                    store;
        logic                    ovf;
    } t_qent;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // One slot of the insertion chain.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        idx;
    } t_cell;

endpackage

[hw/rtl/dsf_front.sv]
// Front end: accepts words, numbers them and tracks capacity and overflow.
module dsf_front
    import dsf_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_item i_item,
    input  t_q_stat  i_q_stat,
    input  logic     i_run_done,
    output logic     o_push,
    output t_qent    o_push_ent
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_pending, n_pending;
    logic          at_cap;
    logic          accept;

    assign busy   = r_pending | i_q_stat.full;
    assign accept = start & ~busy;
    assign at_cap = (r_count == CW'(MAX_ITEMS));

    always_comb begin
        o_push_ent.key   = i_item.depth_key;
        o_push_ent.idx   = IDX_W'(r_count);
        o_push_ent.last  = i_item.last_item;
        o_push_ent.store = ~at_cap;
        o_push_ent.ovf   = r_ovf | at_cap;
    end
    assign o_push = accept;

    always_comb begin
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_pending = r_pending;
        if (i_run_done) begin
            n_pending = 1'b0;
        end
        if (accept) begin
            if (i_item.last_item) begin
                // set closes: restart numbering, hold off until drained
                n_count   = '0;
                n_ovf     = 1'b0;
                n_pending = 1'b1;
            end else if (at_cap) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_pending <= n_pending;
        end
    end

endmodule

[hw/rtl/dsf_queue.sv]
// Two-entry queue between the front end and the sorter.
module dsf_queue
    import dsf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qent   i_push_ent,
    input  logic    i_pop,
    output t_qent   o_head,
    output t_q_stat o_stat
);

    t_qent            r_mem [Q_DEPTH];
    logic [Q_PW-1:0]  r_wp;
    logic [Q_PW-1:0]  r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == Q_FULL_CNT);
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hw/rtl/dsf_back.sv]
// Sorter: insertion chain that keeps keys in descending order, then drains.
module dsf_back
    import dsf_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qent     i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    output logic      o_run_done,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int FW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_back_state;

    t_back_state   r_state, n_state;
    t_cell         r_cell [MAX_ITEMS];
    t_cell         n_cell [MAX_ITEMS];
    logic          gt [MAX_ITEMS];
    logic [FW-1:0] r_fill, n_fill;
    logic          r_ovf, n_ovf;
    logic          r_strobe, n_strobe;
    t_out_item     r_result, n_result;
    t_cell         new_cell;
    logic          insert;
    logic          drain;

    assign new_cell.key = i_head.key;
    assign new_cell.idx = i_head.idx;

    // Slot takes or moves past the new key when empty or strictly smaller;
    // equal keys stay ahead, which keeps arrival order.
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            gt[i] = (FW'(i) >= r_fill) || (i_head.key > r_cell[i].key);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_ovf    = r_ovf;
        n_strobe = 1'b0;
        n_result = r_result;
        o_pop      = 1'b0;
        o_run_done = 1'b0;
        insert     = 1'b0;
        drain      = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (!i_q_stat.empty) begin
                    o_pop  = 1'b1;
                    insert = i_head.store;
                    if (i_head.store) begin
                        n_fill = r_fill + 1'b1;
                    end
                    if (i_head.last) begin
                        n_ovf   = i_head.ovf;
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                drain               = 1'b1;
                n_strobe            = 1'b1;
                n_result.item_index = r_cell[0].idx;
                n_result.sorted_key = r_cell[0].key;
                n_result.last_out   = (r_fill <= FW'(1));
                n_result.overflowed = r_ovf;
                n_fill              = r_fill - 1'b1;
                if (r_fill <= FW'(1)) begin
                    n_fill     = '0;
                    n_state    = ST_LOAD;
                    o_run_done = 1'b1;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        // head slot
        if (insert && gt[0]) begin
            n_cell[0] = new_cell;
        end else if (drain) begin
            n_cell[0] = r_cell[1];
        end else begin
            n_cell[0] = r_cell[0];
        end
        // middle slots
        for (int i = 1; i < MAX_ITEMS - 1; i++) begin
            if (insert && gt[i]) begin
                n_cell[i] = gt[i-1] ? r_cell[i-1] : new_cell;
            end else if (drain) begin
                n_cell[i] = r_cell[i+1];
            end else begin
                n_cell[i] = r_cell[i];
            end
        end
        // tail slot
        if (insert && gt[MAX_ITEMS-1]) begin
            n_cell[MAX_ITEMS-1] = gt[MAX_ITEMS-2] ? r_cell[MAX_ITEMS-2] : new_cell;
        end else begin
            n_cell[MAX_ITEMS-1] = r_cell[MAX_ITEMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[hw/rtl/depth_sort_far_to_near.sv]
// Top level of the far-to-near depth sorter: front end, queue and sorter.
// Usage:
//   Input words (i_item: depth key, last flag) are taken at a rising edge
//   with start high and busy low. Each word is numbered from zero in arrival
//   order. A word with last_item set closes the set.
//   Loading runs at one word per cycle: each key is placed into the
//   insertion chain in the cycle it leaves the two-entry queue, so the set
//   is already in order when the last word arrives.
//   After the last word, results stream on o_result with o_strobe high for
//   one cycle each, one per cycle, highest key first; equal keys come out in
//   arrival order. The last word passes through the queue into the chain
//   before the first result is registered; a set of n stored keys gives n
//   results. last_out marks the final result; overflowed is set on every
//   result of a set that had more than MAX_ITEMS words (extras dropped).
//   busy stays high from the last word until the final result is issued,
//   so the next set starts loading the cycle that final result is shown.
//   The receiver cannot stall; every strobed result must be taken.
//   Reset (synchronous, active low) empties the queue and the chain and
//   restarts numbering; stored keys need no clearing.
`include "assert_macros.svh"

module depth_sort_far_to_near
    import dsf_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic    push;
    t_qent   push_ent;
    logic    pop;
    t_qent   q_head;
    t_q_stat q_stat;
    logic    run_done;

    // front end: numbering, capacity and overflow tracking
    dsf_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_q_stat   (q_stat),
        .i_run_done (run_done),
        .o_push     (push),
        .o_push_ent (push_ent)
    );

    // decoupling queue
    dsf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .i_pop      (pop),
        .o_head     (q_head),
        .o_stat     (q_stat)
    );

    // sorter: insertion chain and drain
    dsf_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_run_done (run_done),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // a drain runs without gaps until its final result
    `DSF_ASSERT(a_drain_contig, i_clk, i_rst_n, (o_strobe && !o_result.last_out) |=> o_strobe, "gap inside a sorted run")
    // the final result of a run is never directly followed by another
    `DSF_ASSERT(a_run_end, i_clk, i_rst_n, (o_strobe && o_result.last_out) |=> !o_strobe, "result right after end of run")
    // a closing word blocks further input until the run drains
    `DSF_ASSERT(a_last_busy, i_clk, i_rst_n, (start && !busy && i_item.last_item) |=> busy, "input open after last word")
    // the queue is never pushed when full
    `DSF_NEVER(a_q_ovr, i_clk, i_rst_n, push && q_stat.full, "queue overrun")

endmodule

[sim/tb.sv]
// Testbench of the far-to-near depth sorter: directed and random sets, stable-sort scoreboard.
module tb
    import dsf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 64;
    localparam int RAND_WORDS = 250;
    localparam int SETTLE     = 8;       // cycles past the last result
    localparam int LIMIT      = 200000;  // cycles
    localparam int SHOW_MAX   = 10;

    // Scoreboard: collects the keys of the set being loaded, and on the closing
    // word works out the whole far-to-near order that the block must stream.
    class depth_order_board;
        logic signed [KEY_W-1:0] set_keys[$];
        logic                    dropped;
        t_out_item               sorted_due[$];
        int                      fails;
        int                      shown;

        function new();
            dropped = 1'b0;
            fails   = 0;
            shown   = 0;
        endfunction

        function int pending();
            return sorted_due.size();
        endfunction

        // Called on every accepted input word.
        function void note_word(t_in_item w);
            int order[$];
            int j;
            t_out_item r;
            if (set_keys.size() < CAPACITY) begin
                set_keys = {set_keys, w.depth_key};
            end else begin
                dropped = 1'b1;
            end
            if (!w.last_item) return;
            // stable insertion, descending: only a strictly larger key moves ahead
            for (int i = 0; i < set_keys.size(); i++) begin
                order = {order, i};
                j = i;
                while (j > 0 && set_keys[order[j-1]] < set_keys[i]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            foreach (order[k]) begin
                r.item_index = order[k][IDX_W-1:0];
                r.sorted_key = set_keys[order[k]];
                r.last_out   = (k == order.size() - 1);
                r.overflowed = dropped;
                sorted_due = {sorted_due, r};
            end
            set_keys.delete();
            dropped = 1'b0;
        endfunction

        // Called on every strobed result.
        function void check_result(t_out_item got);
            t_out_item want;
            if (sorted_due.size() == 0) begin
                fails++;
                if (shown < SHOW_MAX) begin
                    shown++;
                    $display("unexpected result idx=%0d key=%h last=%b ovf=%b",
                             got.item_index, got.sorted_key, got.last_out, got.overflowed);
                end
                return;
            end
            want = sorted_due.pop_front();
            if (got.item_index !== want.item_index || got.sorted_key !== want.sorted_key ||
                got.last_out !== want.last_out || got.overflowed !== want.overflowed) begin
                fails++;
                if (shown < SHOW_MAX) begin
                    shown++;
                    $display("mismatch: exp idx=%0d key=%h last=%b ovf=%b",
                             want.item_index, want.sorted_key, want.last_out, want.overflowed);
                    $display("          got idx=%0d key=%h last=%b ovf=%b",
                             got.item_index, got.sorted_key, got.last_out, got.overflowed);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    depth_order_board sb = new();
    int idle_pct;   // chance in percent of an idle cycle before each word
    int nsent;
    int cycles;

    depth_sort_far_to_near #(.MAX_ITEMS(CAPACITY)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Results cannot be held off: every strobe is a word to check.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("** depth_sort_far_to_near: FAILED **");
            $finish;
        end
    end

    // Mix of ties, extremes and plain random keys.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(7);
        case (sel)
            0, 1: begin
                // small pool of whole values, forces equal keys
                return KEY_W'($signed($urandom_range(4)) - 2) <<< 16;
            end
            2: begin
                return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
            default: begin
                return $signed($urandom());
            end
        endcase
    endfunction

    // Entered and left at a falling edge. Start stays high across back-to-back
    // words; idle cycles carry random noise on the payload.
    task automatic send_word(input logic signed [KEY_W-1:0] key, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            start  = 1'b0;
            i_item = {$urandom(), 1'($urandom())};
            @(negedge i_clk);
        end
        start            = 1'b1;
        i_item.depth_key = key;
        i_item.last_item = last;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_word(i_item);
        nsent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected result has come.
    task automatic wait_drained();
        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_set(input logic signed [KEY_W-1:0] keys[$]);
        foreach (keys[k]) send_word(keys[k], k == keys.size() - 1);
    endtask

    initial begin
        logic signed [KEY_W-1:0] keys[$];
        int set_no;
        int sz;
        int phase;
        int last_phase;

        start    = 1'b0;
        i_item   = '0;
        i_rst_n  = 1'b0;
        idle_pct = 0;
        nsent    = 0;
        cycles   = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed: one-word sets at both extremes
        idle_pct = 35;
        send_set('{32'sh7FFF_FFFF});
        send_set('{32'sh8000_0000});
        // extremes and ties mixed, equal keys must keep arrival order
        send_set('{32'sh0, -32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh1, -32'sh1, 32'sh0, 32'sh7FFF_FFFF});
        // all keys equal
        send_set('{32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678,
                   32'sh1234_5678, 32'sh1234_5678});
        // ascending input comes back reversed
        send_set('{-32'sh2_0000, -32'sh1_0000, 32'sh0, 32'sh1_0000});
        wait_drained();

        // --- random sets; each phase opens with a capacity case:
        //   66 words: extras dropped, the dropped closing word still starts the run
        //   64 words: exactly full, no overflow
        //   65 words: only the closing word is dropped
        nsent      = 0;
        set_no     = 0;
        last_phase = 0;
        while (nsent < RAND_WORDS || set_no <= 16) begin
            phase = (set_no < 8) ? 0 : (set_no < 16) ? 1 : 2;
            if (phase != last_phase) wait_drained();  // sender pause between phases
            last_phase = phase;
            idle_pct = (phase == 0) ? 35 : (phase == 1) ? 83 : 0;
            case (set_no)
                0:       sz = CAPACITY + 2;
                8:       sz = CAPACITY;
                16:      sz = CAPACITY + 1;
                default: sz = $urandom_range(8, 1);
            endcase
            keys.delete();
            repeat (sz) keys = {keys, pick_key()};
            send_set(keys);
            set_no++;
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("** depth_sort_far_to_near: PASSED **");
        end else begin
            $display("** depth_sort_far_to_near: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_front.sv
hw/rtl/dsf_queue.sv
hw/rtl/dsf_back.sv
hw/rtl/depth_sort_far_to_near.sv
sim/tb.sv
